[design/jvbs_pkg.sv]
// Package for the JSON value boundary scanner.
// Holds the character codes, token kinds, scan modes and the token bundle type.
// Used by the front end, queue, back end, top level and checker; depends on nothing.
package jvbs_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int MAX_DEPTH   = 255;
    localparam int DEPTH_BITS  = $clog2(MAX_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        KIND_SEP   = 3'd0,
        KIND_LIT   = 3'd1,
        KIND_BRK   = 3'd2,
        KIND_END   = 3'd3,
        KIND_UNBAL = 3'd4,
        KIND_STRAY = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LIT  = 2'd1,
        MODE_BRK  = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] start_off;
        logic [OFFSET_BITS-1:0] end_off;
    } t_result;

    typedef struct packed {
        logic [1:0]       cnt;
        t_result [2:0]    res;
    } t_bundle;

    function automatic t_bundle push_token(t_bundle bd, t_kind kind,
                                           logic [OFFSET_BITS-1:0] s,
                                           logic [OFFSET_BITS-1:0] e);
        t_bundle nb;
        nb = bd;
        if (bd.cnt != 2'd3) begin
            nb.res[bd.cnt].kind      = kind;
            nb.res[bd.cnt].start_off = s;
            nb.res[bd.cnt].end_off   = e;
            nb.cnt                   = bd.cnt + 2'd1;
        end
        return nb;
    endfunction

endpackage

[design/jvbs_if.sv]
// Handshake interfaces of the scanner: the byte channel and the token channel.
// Each carries valid, ready and the beat payload; depends on nothing.
interface jvbs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jvbs_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        run_last;

    modport source (output valid, output token_kind, output start_offset,
                    output end_offset, output run_last, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input end_offset, input run_last, output ready);
endinterface

[design/jvbs_front.sv]
// Front end of the scanner: accepts byte beats, runs the scan state and
// builds the bundle of up to three tokens caused by each byte.
// Depends on jvbs_pkg and jvbs_if.
module jvbs_front
    import jvbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    jvbs_byte_if.sink i_byte,
    input  logic    i_q_full,
    output logic    o_push,
    output t_bundle o_bundle
);

    t_mode                  r_mode, n_mode, mid_mode;
    logic [DEPTH_BITS-1:0]  r_lvl, n_lvl, br_lvl;
    logic                   r_inq, n_inq, br_inq;
    logic                   r_esc, n_esc, br_esc;
    logic                   r_ovf, n_ovf, br_ovf;
    logic                   r_dot, n_dot;
    logic [OFFSET_BITS-1:0] r_tb, n_tb, mid_tb;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, pos_inc;

    logic [7:0] b;
    logic accept, last;
    logic b_space, b_sep, b_closer, b_opener, b_quote, b_bslash, b_dot, b_minus;
    logic lit_end, go_idle, idle_sep, idle_stray, idle_brk, idle_lit, brk_done;

    assign b      = i_byte.data_byte;
    assign last   = i_byte.final_byte;
    assign accept = i_byte.valid && !i_q_full;
    assign i_byte.ready = !i_q_full;
    assign pos_inc = r_pos + OFFSET_BITS'(1);

    assign b_space  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    assign b_sep    = (b == CH_COLON) || (b == CH_COMMA) || (b == CH_EQUAL);
    assign b_closer = (b == CH_RBRACK) || (b == CH_RBRACE);
    assign b_opener = (b == CH_LBRACK) || (b == CH_LBRACE);
    assign b_quote  = (b == CH_QUOTE);
    assign b_bslash = (b == CH_BSLASH);
    assign b_dot    = (b == CH_DOT);
    assign b_minus  = (b == CH_MINUS);

    assign lit_end  = (r_mode == MODE_LIT) &&
                      (b_space || b_sep || b_closer || b_opener || b_quote || b_minus ||
                       (b_dot && r_dot));
    assign go_idle    = (r_mode == MODE_IDLE) || lit_end;
    assign idle_sep   = go_idle && b_sep;
    assign idle_stray = go_idle && b_closer;
    assign idle_brk   = go_idle && (b_opener || b_quote);
    assign idle_lit   = go_idle && !b_space && !b_sep && !b_closer && !b_opener && !b_quote;

    // Nesting update for a byte inside a bracketed or quoted value.
    always_comb begin
        br_lvl = r_lvl;
        br_inq = r_inq;
        br_esc = r_esc;
        br_ovf = r_ovf;
        if (!r_inq) begin
            if (b_opener || b_quote) begin
                if (r_lvl >= DEPTH_BITS'(MAX_DEPTH)) begin
                    br_ovf = 1'b1;
                end else begin
                    br_lvl = r_lvl + DEPTH_BITS'(1);
                end
                if (b_quote) begin
                    br_inq = 1'b1;
                end
            end else if (b_closer) begin
                if (r_lvl != '0) begin
                    br_lvl = r_lvl - DEPTH_BITS'(1);
                end
            end
        end else begin
            if (b_quote && !r_esc) begin
                if (r_lvl != '0) begin
                    br_lvl = r_lvl - DEPTH_BITS'(1);
                end
                br_inq = 1'b0;
            end else if (b_quote || b_bslash) begin
                br_esc = !r_esc;
            end else begin
                br_esc = 1'b0;
            end
        end
    end

    assign brk_done = (r_mode == MODE_BRK) && (br_lvl == '0);

    // Next state.
    always_comb begin
        mid_mode = r_mode;
        mid_tb   = r_tb;
        n_lvl    = r_lvl;
        n_inq    = r_inq;
        n_esc    = r_esc;
        n_ovf    = r_ovf;
        n_dot    = r_dot;
        unique case (r_mode)
            MODE_LIT: begin
                if (lit_end) begin
                    mid_mode = MODE_IDLE;
                    n_dot    = 1'b0;
                end else if (b_dot) begin
                    n_dot = 1'b1;
                end
            end
            MODE_BRK: begin
                n_lvl = br_lvl;
                n_inq = br_inq;
                n_esc = br_esc;
                n_ovf = br_ovf;
                if (brk_done) begin
                    mid_mode = MODE_IDLE;
                    n_inq    = 1'b0;
                    n_esc    = 1'b0;
                    n_ovf    = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (idle_brk) begin
            mid_mode = MODE_BRK;
            mid_tb   = r_pos;
            n_lvl    = DEPTH_BITS'(1);
            n_inq    = b_quote;
            n_esc    = 1'b0;
            n_ovf    = 1'b0;
        end else if (idle_lit) begin
            mid_mode = MODE_LIT;
            mid_tb   = r_pos;
            n_dot    = b_dot;
        end
        n_mode = mid_mode;
        n_tb   = mid_tb;
        n_pos  = pos_inc;
        if (last) begin
            n_mode = MODE_IDLE;
            n_tb   = '0;
            n_pos  = '0;
            n_lvl  = '0;
            n_inq  = 1'b0;
            n_esc  = 1'b0;
            n_ovf  = 1'b0;
            n_dot  = 1'b0;
        end
    end

    // Tokens caused by the byte, in stream order.
    always_comb begin
        t_bundle bd;
        bd = '0;
        if (lit_end) begin
            bd = push_token(bd, KIND_LIT, r_tb, r_pos);
        end
        if (idle_sep) begin
            bd = push_token(bd, KIND_SEP, r_pos, pos_inc);
        end
        if (idle_stray) begin
            bd = push_token(bd, KIND_STRAY, r_pos, pos_inc);
        end
        if (brk_done) begin
            bd = push_token(bd, br_ovf ? KIND_UNBAL : KIND_BRK, r_tb, pos_inc);
        end
        if (last) begin
            if (mid_mode == MODE_LIT) begin
                bd = push_token(bd, KIND_LIT, mid_tb, pos_inc);
            end else if (mid_mode == MODE_BRK) begin
                bd = push_token(bd, KIND_UNBAL, mid_tb, pos_inc);
            end
            bd = push_token(bd, KIND_END, pos_inc, pos_inc);
        end
        o_bundle = bd;
    end

    assign o_push = accept && (o_bundle.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_lvl  <= '0;
            r_inq  <= 1'b0;
            r_esc  <= 1'b0;
            r_ovf  <= 1'b0;
            r_dot  <= 1'b0;
            r_tb   <= '0;
            r_pos  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_lvl  <= n_lvl;
            r_inq  <= n_inq;
            r_esc  <= n_esc;
            r_ovf  <= n_ovf;
            r_dot  <= n_dot;
            r_tb   <= n_tb;
            r_pos  <= n_pos;
        end
    end

endmodule

[design/jvbs_queue.sv]
// Short queue of token bundles between the front end and the back end.
// Depends on jvbs_pkg.
module jvbs_queue
    import jvbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_full,
    output logic    o_empty
);

    t_bundle               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr, r_rd;
    logic [QCNT_BITS-1:0]  r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
        end
    end

endmodule

[design/jvbs_back.sv]
// Back end of the scanner: takes bundles from the queue and sends their
// tokens one beat at a time through a registered output stage.
// Depends on jvbs_pkg and jvbs_if.
module jvbs_back
    import jvbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  logic    i_empty,
    output logic    o_pop,
    jvbs_tok_if.source o_tok
);

    logic       r_valid;
    t_result    r_tok;
    logic       r_last;
    logic [1:0] r_idx;
    logic       load, head_last;

    assign load      = !i_empty && (!r_valid || o_tok.ready);
    assign head_last = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop     = load && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= head_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.res[r_idx];
            r_last <= head_last;
        end
    end

    assign o_tok.valid        = r_valid;
    assign o_tok.token_kind   = r_tok.kind;
    assign o_tok.start_offset = r_tok.start_off;
    assign o_tok.end_offset   = r_tok.end_off;
    assign o_tok.run_last     = r_last;

endmodule

[design/json_value_boundary_scanner.sv]
// Top level of the JSON value boundary scanner.
// Depends on jvbs_pkg, jvbs_if, jvbs_front, jvbs_queue and jvbs_back.
//
// Usage: bytes of a text stream arrive one per beat on i_byte, with
// final_byte set on the last byte of a stream. Each token leaves on o_tok
// as one beat with its kind, start and end offsets; run_last marks the last
// token caused by one input byte. The front end classifies a byte in the
// cycle it is accepted and writes its tokens into the four-entry bundle queue
// at that same edge, so a byte is accepted every cycle while the queue has room.
// The tokens of a byte pass from the queue through the registered output stage.
// The output stage sends one token per cycle while o_tok.ready is high, so
// a run of bytes that each cause tokens is paced by the output port; the queue
// absorbs short bursts. When o_tok.ready is low the output beat holds, the queue
// fills, and then i_byte.ready drops until the output stage takes the last token
// of the oldest queued byte. Reset clears the scan state, the queue and the
// output stage; offsets count from zero again, as they do after every final byte.
module json_value_boundary_scanner
    import jvbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    jvbs_byte_if.sink  i_byte,
    jvbs_tok_if.source o_tok
);

    logic    push, pop, q_full, q_empty;
    t_bundle push_bundle, head;

    jvbs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    jvbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    jvbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

endmodule

[design/jvbs_checker.sv]
// Port-level checks for the JSON value boundary scanner, bound to its top level.
// Depends on jvbs_pkg and json_value_boundary_scanner.
module jvbs_checker
    import jvbs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [31:0] i_out_start,
    input logic [31:0] i_out_end,
    input logic        i_out_last
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("token beat offered right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
        $stable(i_out_start) && $stable(i_out_end) && $stable(i_out_last))
        else $error("stalled token beat changed");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_END) |-> i_out_last && (i_out_start == i_out_end))
        else $error("end token is not an empty final beat");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_kind == KIND_SEP) || (i_out_kind == KIND_STRAY)) |->
        (i_out_end == i_out_start + 32'd1))
        else $error("separator or stray closer is not one byte long");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind != 3'd6) && (i_out_kind != 3'd7))
        else $error("token kind out of range");

endmodule

bind json_value_boundary_scanner jvbs_checker u_jvbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_out_kind  (o_tok.token_kind),
    .i_out_start (o_tok.start_offset),
    .i_out_end   (o_tok.end_offset),
    .i_out_last  (o_tok.run_last)
);
